@@ rtl/bsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and helpers for the Booth signed multiplier core.
// ----------------------------------------------------------------------------
package bsm_pkg;

  typedef enum logic [1:0] {
    BOOTH_NOP = 2'b00,
    BOOTH_ADD = 2'b01,
    BOOTH_SUB = 2'b10
  } booth_op_t;

  // Radix-2 recoding of the pair {Q bit 0, extra bit}.
  function automatic booth_op_t booth_op(input logic q0, input logic extra);
    booth_op_t op;
    unique case ({q0, extra})
      2'b10:   op = BOOTH_SUB;
      2'b01:   op = BOOTH_ADD;
      default: op = BOOTH_NOP;
    endcase
    return op;
  endfunction

endpackage

@@ rtl/booth_signed_multiplier_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// booth_signed_multiplier_core
// Radix-2 Booth multiplier, one recoding step per pipeline stage.
// ----------------------------------------------------------------------------
// Input stream s_*: one item holds the multiplicand and multiplier patterns
// (read as two's complement) and a separate sign bit for each. Output
// stream m_*: the 2*WIDTH-bit product pattern and a negative flag, the XOR
// of the two sign bits.
// Pipeline: WIDTH stages, one stage per Booth step. Throughput: one item
// per cycle while m_tready is high, set by the WIDTH-stage pipeline.
// Each stage has its own valid bit and loads when empty or when the next
// stage moves, so bubbles close up and a stalled output register holds its
// item while earlier stages keep filling.
// When m_tready stays low the pipeline fills; s_tready drops only once all
// WIDTH stages hold items. Nothing is lost or repeated.
// Reset clears every valid bit; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
module booth_signed_multiplier_core #(
  parameter int WIDTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // multiplicand, multiplicand_sign, multiplier, multiplier_sign, zero pad
  input  logic [((2*WIDTH+2+7)/8)*8-1:0]       s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // product, negative, zero pad
  output logic [((2*WIDTH+1+7)/8)*8-1:0]       m_tdata
);

  localparam int ODW = ((2*WIDTH+1+7)/8)*8;

  logic             v     [WIDTH+1];
  logic             r     [WIDTH+1];
  logic [WIDTH-1:0] acc   [WIDTH+1];
  logic [WIDTH-1:0] q     [WIDTH+1];
  logic             extra [WIDTH+1];
  logic [WIDTH-1:0] m     [WIDTH+1];
  logic             neg   [WIDTH+1];

  assign v[0]     = s_tvalid;
  assign s_tready = r[0];
  assign acc[0]   = '0;
  assign m[0]     = s_tdata[WIDTH-1:0];
  assign q[0]     = s_tdata[2*WIDTH:WIDTH+1];
  assign extra[0] = 1'b0;
  assign neg[0]   = s_tdata[WIDTH] ^ s_tdata[2*WIDTH+1];

  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    bsm_stage #(.WIDTH(WIDTH)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[k]),
      .in_ready  (r[k]),
      .in_acc    (acc[k]),
      .in_q      (q[k]),
      .in_extra  (extra[k]),
      .in_m      (m[k]),
      .in_neg    (neg[k]),
      .out_valid (v[k+1]),
      .out_ready (r[k+1]),
      .out_acc   (acc[k+1]),
      .out_q     (q[k+1]),
      .out_extra (extra[k+1]),
      .out_m     (m[k+1]),
      .out_neg   (neg[k+1])
    );
  end

  assign r[WIDTH]  = m_tready;
  assign m_tvalid  = v[WIDTH];
  assign m_tdata   = {{(ODW-2*WIDTH-1){1'b0}}, neg[WIDTH], acc[WIDTH], q[WIDTH]};

endmodule

@@ rtl/bsm_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_stage
// One registered Booth step: add/subtract into the accumulator, then
// arithmetic shift of acc:q:extra. Carries the sign flag and multiplicand.
// ----------------------------------------------------------------------------
module bsm_stage #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_acc,
  input  logic [WIDTH-1:0] in_q,
  input  logic             in_extra,
  input  logic [WIDTH-1:0] in_m,
  input  logic             in_neg,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_acc,
  output logic [WIDTH-1:0] out_q,
  output logic             out_extra,
  output logic [WIDTH-1:0] out_m,
  output logic             out_neg
);
  import bsm_pkg::*;

  booth_op_t        op;
  logic [WIDTH-1:0] sum;
  logic [WIDTH-1:0] acc_next;
  logic [WIDTH-1:0] q_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    op = booth_op(in_q[0], in_extra);
    unique case (op)
      BOOTH_ADD: sum = in_acc + in_m;
      BOOTH_SUB: sum = in_acc - in_m;
      default:   sum = in_acc;
    endcase
    acc_next = {sum[WIDTH-1], sum[WIDTH-1:1]};
    q_next   = {sum[0], in_q[WIDTH-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_acc   <= acc_next;
      out_q     <= q_next;
      out_extra <= in_q[0];
      out_m     <= in_m;
      out_neg   <= in_neg;
    end
  end

endmodule

@@ rtl/bsm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level checks for the Booth multiplier core, bound to the top level.
// ----------------------------------------------------------------------------
module bsm_checker #(
  parameter int WIDTH = 8
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [((2*WIDTH+1+7)/8)*8-1:0] m_tdata
);

  localparam int ODW = ((2*WIDTH+1+7)/8)*8;

  // held output item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // input backpressure only when the whole pipeline is full and stalled
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");

  // pad bits above the flag are zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[ODW-1:2*WIDTH+1] == '0)
    else $error("output pad bits not zero");

endmodule

bind booth_signed_multiplier_core bsm_checker #(.WIDTH(WIDTH)) u_bsm_checker (.*);
